FILE: src/assert_macros.svh
// Assertion macros shared by the text scroller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define TSCG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tscg assertion failed");

// Condition that must never be true.
`define TSCG_ASSERT_NEVER(lbl, clk, rst_n, expr) `TSCG_ASSERT(lbl, clk, rst_n, !(expr))

`endif

FILE: src/tscg_pkg.sv
// Types, constants, font ROM and wave table of the text scroll column generator.
package tscg_pkg;

  localparam int unsigned MAX_MODULES   = 8;
  localparam int unsigned MAX_CHARS_DEF = 64;

  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned TW_W       = 9;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned COLX_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QAW         = $clog2(QUEUE_DEPTH);

  localparam logic [9:0] RECIP_6     = 10'd683;
  localparam int unsigned RECIP_SHIFT = 12;

  localparam logic [1:0] KIND_ARM    = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [1:0] MODE_GAP  = 2'd0;
  localparam logic [1:0] MODE_WRAP = 2'd1;
  localparam logic [1:0] MODE_EXIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_ENABLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODULES = 2'd3;

  localparam logic [3:0] DMOD_RESET = 4'd8;
  localparam logic [2:0] COL_BLANK  = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
  } req_t;

  typedef struct packed {
    logic [7:0]        column_bits;
    logic [COLX_W-1:0] column_index;
    logic              last;
    logic              stopped;
  } res_t;

  typedef struct packed {
    logic                    stop;
    logic                    wrap;
    logic                    wave_en;
    logic [3:0]              phase;
    logic [COLX_W-1:0]       last_col;
    logic [TW_W-1:0]         tw;
    logic signed [POS_W-1:0] t0;
  } job_t;

  function automatic int unsigned addr_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic [7:0] font_col(logic [CHAR_W-1:0] code, logic [2:0] col);
    logic [39:0] row;
    case (code)
      7'h20: row = 40'h0000000000;
      7'h21: row = 40'h00005F0000;
      7'h22: row = 40'h0007000700;
      7'h23: row = 40'h147F147F14;
      7'h24: row = 40'h242A7F2A12;
      7'h25: row = 40'h2313086462;
      7'h26: row = 40'h3649552250;
      7'h27: row = 40'h0005030000;
      7'h28: row = 40'h001C224100;
      7'h29: row = 40'h0041221C00;
      7'h2A: row = 40'h14083E0814;
      7'h2B: row = 40'h08083E0808;
      7'h2C: row = 40'h0050300000;
      7'h2D: row = 40'h0808080808;
      7'h2E: row = 40'h0060600000;
      7'h2F: row = 40'h2010080402;
      7'h30: row = 40'h3E5149453E;
      7'h31: row = 40'h00427F4000;
      7'h32: row = 40'h4261514946;
      7'h33: row = 40'h2141454B31;
      7'h34: row = 40'h1814127F10;
      7'h35: row = 40'h2745454539;
      7'h36: row = 40'h3C4A494930;
      7'h37: row = 40'h0171090503;
      7'h38: row = 40'h3649494936;
      7'h39: row = 40'h064949291E;
      7'h3A: row = 40'h0036360000;
      7'h3B: row = 40'h0056360000;
      7'h3C: row = 40'h0814224100;
      7'h3D: row = 40'h1414141414;
      7'h3E: row = 40'h0041221408;
      7'h3F: row = 40'h0201510906;
      7'h40: row = 40'h324979413E;
      7'h41: row = 40'h7C1211127C;
      7'h42: row = 40'h7F49494936;
      7'h43: row = 40'h3E41414122;
      7'h44: row = 40'h7F4141221C;
      7'h45: row = 40'h7F49494941;
      7'h46: row = 40'h7F09090901;
      7'h47: row = 40'h3E4149497A;
      7'h48: row = 40'h7F0808087F;
      7'h49: row = 40'h00417F4100;
      7'h4A: row = 40'h2040413F01;
      7'h4B: row = 40'h7F08142241;
      7'h4C: row = 40'h7F40404040;
      7'h4D: row = 40'h7F020C027F;
      7'h4E: row = 40'h7F0408107F;
      7'h4F: row = 40'h3E4141413E;
      7'h50: row = 40'h7F09090906;
      7'h51: row = 40'h3E4151215E;
      7'h52: row = 40'h7F09192946;
      7'h53: row = 40'h4649494931;
      7'h54: row = 40'h01017F0101;
      7'h55: row = 40'h3F4040403F;
      7'h56: row = 40'h1F2040201F;
      7'h57: row = 40'h3F4038403F;
      7'h58: row = 40'h6314081463;
      7'h59: row = 40'h0708700807;
      7'h5A: row = 40'h6151494543;
      7'h5B: row = 40'h007F414100;
      7'h5C: row = 40'h0204081020;
      7'h5D: row = 40'h0041417F00;
      7'h5E: row = 40'h0402010204;
      7'h5F: row = 40'h4040404040;
      7'h60: row = 40'h0001020400;
      7'h7B: row = 40'h0008364100;
      7'h7C: row = 40'h00007F0000;
      7'h7D: row = 40'h0041360800;
      7'h7E: row = 40'h0804081008;
      default: row = 40'h0000000000;
    endcase
    case (col)
      3'd0: return row[39:32];
      3'd1: return row[31:24];
      3'd2: return row[23:16];
      3'd3: return row[15:8];
      3'd4: return row[7:0];
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] wave_shift(logic [7:0] bits, logic [3:0] widx);
    case (widx[2:0]) inside
      3'd1, 3'd3: return bits << 1;
      3'd2:       return bits << 2;
      3'd5, 3'd7: return bits >> 1;
      3'd6:       return bits >> 2;
      default:    return bits;
    endcase
  endfunction

endpackage

FILE: src/tscg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tscg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [tscg_pkg::addr_w(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                   wdata_i,
  input  logic                               re_i,
  input  logic [tscg_pkg::addr_w(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]                   rdata_o
);
  import tscg_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/tscg_queue.sv
// Short job queue between the request front end and the column generator.
`include "assert_macros.svh"

module tscg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tscg_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tscg_pkg::job_t job_o,
  output logic           empty_o
);
  import tscg_pkg::*;

  job_t           mem_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QAW:0]   cnt_q, cnt_d;

  always_comb begin
    full_o  = (cnt_q == (QAW+1)'(QUEUE_DEPTH));
    empty_o = (cnt_q == '0);
    valid_o = !empty_o;
    job_o   = mem_q[rd_q];
    wr_d    = push_i ? wr_q + 1'b1 : wr_q;
    rd_d    = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d   = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  `TSCG_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o)
  `TSCG_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o)

endmodule

FILE: src/tscg_front.sv
// Request front end: configuration, text store writes and scroll position control.
`include "assert_macros.svh"

module tscg_front #(
  parameter int unsigned MAX_CHARS = tscg_pkg::MAX_CHARS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  tscg_pkg::req_t                         in_req_i,
  input  logic                                   cfg_valid_i,
  input  logic [tscg_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tscg_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                   ram_we_o,
  output logic [tscg_pkg::addr_w(MAX_CHARS)-1:0] ram_waddr_o,
  output logic [tscg_pkg::CHAR_W-1:0]            ram_wdata_o,
  output logic                                   q_push_o,
  output tscg_pkg::job_t                         q_job_o,
  input  logic                                   q_full_i,
  input  logic                                   q_empty_i,
  input  logic                                   back_busy_i
);
  import tscg_pkg::*;

  localparam int unsigned AW    = addr_w(MAX_CHARS);
  localparam int unsigned LEN_W = $clog2(MAX_CHARS + 1);

  logic [1:0]              loop_mode_q, loop_mode_d;
  logic                    wave_en_q, wave_en_d;
  logic [15:0]             limit_q, limit_d;
  logic [3:0]              dmod_q, dmod_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic signed [POS_W-1:0] pos_q, pos_d;
  logic [3:0]              phase_q, phase_d;
  logic [15:0]             cnt_q, cnt_d;
  logic                    running_q, running_d;
  logic                    restart_q, restart_d;

  logic                    accept, tick_acc;
  logic [7:0]              up_char;
  logic [CHAR_W-1:0]       norm_char;
  logic [3:0]              modules;
  logic [6:0]              width;
  logic [TW_W-1:0]         tw;
  logic signed [POS_W-1:0] width_s, tw_s, ntw_s, pos_cur, pos_step, pos_new;
  logic [1:0]              mode;
  logic                    wrapped, stop;
  logic [15:0]             cnt_inc;

  always_comb begin
    in_stall_o = ((in_req_i.kind == KIND_TICK) && q_full_i) ||
                 ((in_req_i.kind == KIND_ARM) && (!q_empty_i || back_busy_i));
    accept   = in_valid_i && !in_stall_o;
    tick_acc = accept && (in_req_i.kind == KIND_TICK);

    up_char = in_req_i.char_code;
    if (up_char >= 8'h61 && up_char <= 8'h7A) begin
      up_char = up_char - 8'h20;
    end
    norm_char = (up_char < 8'h20 || up_char > 8'h7E) ? 7'h20 : up_char[CHAR_W-1:0];

    if (dmod_q == 4'd0) begin
      modules = 4'd1;
    end else if (dmod_q > 4'(MAX_MODULES)) begin
      modules = 4'(MAX_MODULES);
    end else begin
      modules = dmod_q;
    end
    width   = {modules, 3'b000};
    width_s = $signed({{(POS_W-7){1'b0}}, width});
    tw      = (TW_W'(len_q) << 2) + (TW_W'(len_q) << 1);
    tw_s    = $signed({{(POS_W-TW_W){1'b0}}, tw});
    ntw_s   = -tw_s;
    mode    = (loop_mode_q == MODE_WRAP || loop_mode_q == MODE_EXIT) ? loop_mode_q : MODE_GAP;

    pos_cur = pos_q;
    if (restart_q) begin
      unique case (mode)
        MODE_WRAP: pos_cur = '0;
        MODE_EXIT: pos_cur = ntw_s;
        default:   pos_cur = width_s;
      endcase
    end

    wrapped = 1'b0;
    unique case (mode)
      MODE_WRAP: begin
        pos_step = pos_cur - POS_W'(1);
        pos_new  = pos_step;
        if (pos_step <= ntw_s) begin
          pos_new = pos_step + tw_s;
          wrapped = 1'b1;
        end
      end
      MODE_EXIT: begin
        pos_step = pos_cur + POS_W'(1);
        pos_new  = pos_step;
        if (pos_step > width_s) begin
          pos_new = ntw_s;
          wrapped = 1'b1;
        end
      end
      default: begin
        pos_step = pos_cur - POS_W'(1);
        pos_new  = pos_step;
        if (pos_step < ntw_s) begin
          pos_new = width_s;
          wrapped = 1'b1;
        end
      end
    endcase

    cnt_inc = cnt_q + 16'd1;
    stop    = wrapped && (limit_q != 16'd0) && (cnt_inc >= limit_q);

    q_push_o          = tick_acc && running_q && (len_q != '0);
    q_job_o.stop      = stop;
    q_job_o.wrap      = (mode == MODE_WRAP);
    q_job_o.wave_en   = wave_en_q;
    q_job_o.phase     = phase_q;
    q_job_o.last_col  = COLX_W'(width - 7'd1);
    q_job_o.tw        = tw;
    q_job_o.t0        = -pos_cur;

    ram_we_o    = accept && (in_req_i.kind == KIND_APPEND) && (len_q < LEN_W'(MAX_CHARS));
    ram_waddr_o = len_q[AW-1:0];
    ram_wdata_o = norm_char;

    loop_mode_d = loop_mode_q;
    wave_en_d   = wave_en_q;
    limit_d     = limit_q;
    dmod_d      = dmod_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOOP_MODE:       loop_mode_d = cfg_data_i[1:0];
        CFG_WAVE_ENABLE:     wave_en_d   = cfg_data_i[0];
        CFG_REPEAT_LIMIT:    limit_d     = cfg_data_i;
        CFG_DISPLAY_MODULES: dmod_d      = cfg_data_i[3:0];
        default:             ;
      endcase
    end

    len_d     = len_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    running_d = running_q;
    restart_d = restart_q;
    if (accept) begin
      unique case (in_req_i.kind)
        KIND_ARM: begin
          len_d     = '0;
          running_d = 1'b1;
          restart_d = 1'b1;
          cnt_d     = '0;
        end
        KIND_APPEND: begin
          if (ram_we_o) begin
            len_d     = len_q + 1'b1;
            restart_d = 1'b1;
          end
        end
        KIND_TICK: begin
          if (q_push_o) begin
            pos_d     = pos_new;
            restart_d = 1'b0;
            if (wrapped && limit_q != 16'd0) begin
              cnt_d = cnt_inc;
            end
            if (stop) begin
              running_d = 1'b0;
              phase_d   = '0;
            end else begin
              phase_d = phase_q + 4'd1;
            end
          end else begin
            phase_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_mode_q <= MODE_GAP;
      wave_en_q   <= 1'b0;
      limit_q     <= '0;
      dmod_q      <= DMOD_RESET;
      len_q       <= '0;
      pos_q       <= '0;
      phase_q     <= '0;
      cnt_q       <= '0;
      running_q   <= 1'b0;
      restart_q   <= 1'b0;
    end else begin
      loop_mode_q <= loop_mode_d;
      wave_en_q   <= wave_en_d;
      limit_q     <= limit_d;
      dmod_q      <= dmod_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      running_q   <= running_d;
      restart_q   <= restart_d;
    end
  end

  `TSCG_ASSERT(a_idle_phase, clk_i, rst_ni, !running_q |-> (phase_q == 4'd0))
  `TSCG_ASSERT(a_stop_on_tick, clk_i, rst_ni, $fell(running_q) |-> $past(tick_acc))

endmodule

FILE: src/tscg_back.sv
// Column generator: walks one tick job column by column through the text store.
`include "assert_macros.svh"

module tscg_back #(
  parameter int unsigned MAX_CHARS = tscg_pkg::MAX_CHARS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_valid_i,
  input  tscg_pkg::job_t                         q_job_i,
  output logic                                   q_pop_o,
  output logic                                   busy_o,
  output logic                                   ram_re_o,
  output logic [tscg_pkg::addr_w(MAX_CHARS)-1:0] ram_raddr_o,
  input  logic [tscg_pkg::CHAR_W-1:0]            ram_rdata_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output tscg_pkg::res_t                         out_res_o
);
  import tscg_pkg::*;

  localparam int unsigned AW = addr_w(MAX_CHARS);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_FIX, ST_RUN} state_e;

  typedef struct packed {
    logic              stop;
    logic              vis;
    logic [2:0]        col;
    logic [3:0]        widx;
    logic              wave_en;
    logic [COLX_W-1:0] x;
    logic              last;
  } slot_t;

  state_e                  state_q;
  job_t                    job_q;
  logic signed [POS_W-1:0] t_q;
  logic [IDX_W-1:0]        idx_q;
  logic [2:0]              col_q;
  logic [COLX_W-1:0]       x_q;
  slot_t                   s1_q, run_s1, stop_s1;
  logic                    s1_v_q, out_v_q;
  res_t                    out_q, out_d;

  logic                    out_adv, adv1, run_issue, stop_issue, vis;
  logic signed [POS_W-1:0] tw_s, t_inc;
  logic [19:0]             prod;
  logic [POS_W-1:0]        six_idx, col_diff;
  logic [7:0]              glyph, shaped;

  always_comb begin
    out_adv    = !out_v_q || !out_stall_i;
    adv1       = !s1_v_q || out_adv;
    q_pop_o    = (state_q == ST_IDLE) && q_valid_i && (!q_job_i.stop || adv1);
    stop_issue = (state_q == ST_IDLE) && q_valid_i && q_job_i.stop && adv1;
    run_issue  = (state_q == ST_RUN) && adv1;
    busy_o     = (state_q != ST_IDLE);

    tw_s  = $signed({{(POS_W-TW_W){1'b0}}, job_q.tw});
    t_inc = t_q + POS_W'(1);
    vis   = (t_q >= 0) && (t_q < tw_s) && (col_q != COL_BLANK);

    ram_re_o    = run_issue;
    ram_raddr_o = idx_q[AW-1:0];

    prod     = 20'(job_q.t0[9:0]) * 20'(RECIP_6);
    six_idx  = (POS_W'(idx_q) << 2) + (POS_W'(idx_q) << 1);
    col_diff = t_q - six_idx;

    run_s1.stop    = 1'b0;
    run_s1.vis     = vis;
    run_s1.col     = col_q;
    run_s1.widx    = job_q.phase + {idx_q[2:0], 1'b0};
    run_s1.wave_en = job_q.wave_en;
    run_s1.x       = x_q;
    run_s1.last    = (x_q == job_q.last_col);

    stop_s1.stop    = 1'b1;
    stop_s1.vis     = 1'b0;
    stop_s1.col     = '0;
    stop_s1.widx    = '0;
    stop_s1.wave_en = 1'b0;
    stop_s1.x       = '0;
    stop_s1.last    = 1'b1;

    glyph  = font_col(ram_rdata_i, s1_q.col);
    shaped = s1_q.wave_en ? wave_shift(glyph, s1_q.widx) : glyph;

    out_d.column_bits  = s1_q.vis ? shaped : 8'h00;
    out_d.column_index = s1_q.x;
    out_d.last         = s1_q.last;
    out_d.stopped      = s1_q.stop;

    out_valid_o = out_v_q;
    out_res_o   = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= '0;
      t_q     <= '0;
      idx_q   <= '0;
      col_q   <= '0;
      x_q     <= '0;
      s1_v_q  <= 1'b0;
      s1_q    <= '0;
      out_v_q <= 1'b0;
      out_q   <= '0;
    end else begin
      if (out_adv) begin
        out_v_q <= s1_v_q;
        if (s1_v_q) begin
          out_q <= out_d;
        end
      end
      if (adv1) begin
        s1_v_q <= run_issue || stop_issue;
        if (run_issue) begin
          s1_q <= run_s1;
        end else if (stop_issue) begin
          s1_q <= stop_s1;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_pop_o && !q_job_i.stop) begin
            job_q   <= q_job_i;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          t_q   <= job_q.t0;
          idx_q <= (job_q.t0 >= 0) ? IDX_W'(prod >> RECIP_SHIFT) : '0;
          col_q <= '0;
          x_q   <= '0;
          state_q <= ST_FIX;
        end
        ST_FIX: begin
          col_q   <= (t_q >= 0) ? col_diff[2:0] : 3'd0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (adv1) begin
            x_q <= x_q + 1'b1;
            if (job_q.wrap && t_inc == tw_s) begin
              t_q   <= '0;
              idx_q <= '0;
              col_q <= '0;
            end else begin
              t_q <= t_inc;
              if (t_q >= 0) begin
                if (col_q == COL_BLANK) begin
                  col_q <= '0;
                  idx_q <= idx_q + 1'b1;
                end else begin
                  col_q <= col_q + 3'd1;
                end
              end
            end
            if (x_q == job_q.last_col) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `TSCG_ASSERT(a_stop_shape, clk_i, rst_ni, (out_v_q && out_q.stopped) |-> (out_q.last && out_q.column_bits == 8'h00))

endmodule

FILE: src/text_scroll_column_generator_top.sv
// Top level of the scrolling text column generator for an 8-row LED matrix.
// Input channel (in_valid_i / in_stall_o, payload in_req_i): kind 0 clears the text and
// arms the scroll, kind 1 appends one character, kind 2 is a frame tick.
// Output channel (out_valid_o / out_stall_i, payload out_res_o): one request per display
// column, left to right, last set on the final column of a tick; a tick that reaches the
// repeat limit yields a single request with stopped and last set instead.
// Configuration channel (cfg_valid_i / cfg_ready_o): cfg_index_i picks loop_mode,
// wave_enable, repeat_limit or display_modules; write only while the block is idle.
// Appends and arms are taken by the front end; an arm holds off until the column
// generator has drained, since it restarts the text store from entry zero.
// A scrolling tick is queued as one job; the column generator loads its start position,
// fixes the starting column, then delivers one column per cycle while the output is not
// stalled, reading the text store and the font ROM.
// Up to two ticks queue up while columns are still being delivered.
// A stall on the output holds the output register and freezes the column walk.
// Reset clears all control state and returns the configuration to its defaults; the text
// store is undefined until written.
module text_scroll_column_generator_top #(
  parameter int unsigned MAX_CHARS = tscg_pkg::MAX_CHARS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tscg_pkg::req_t                  in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tscg_pkg::res_t                  out_res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tscg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tscg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tscg_pkg::*;

  localparam int unsigned AW = addr_w(MAX_CHARS);

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;
  logic              q_push, q_full, q_pop, q_valid, q_empty, back_busy;
  job_t              q_job_in, q_job_out;

  assign cfg_ready_o = 1'b1;

  tscg_front #(
    .MAX_CHARS(MAX_CHARS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .q_push_o    (q_push),
    .q_job_o     (q_job_in),
    .q_full_i    (q_full),
    .q_empty_i   (q_empty),
    .back_busy_i (back_busy)
  );

  tscg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job_out),
    .empty_o (q_empty)
  );

  tscg_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(MAX_CHARS)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tscg_back #(
    .MAX_CHARS(MAX_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job_out),
    .q_pop_o     (q_pop),
    .busy_o      (back_busy),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule
